>>> rtl/srms_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srms_pkg
// Shared widths, defaults and register codes of the stable run merge sorter.
// ---------------------------------------------------------------------------
package srms_pkg;

   localparam int KEY_PORT_BITS = 32;   // width of key fields on the ports
   localparam int POS_BITS      = 6;    // load position stored with each key

   localparam int MAX_ITEMS_DEF = 64;
   localparam int KEY_BITS_DEF  = 32;

   // configuration register index (paddr[2])
   localparam logic CSR_IDX_DESCENDING = 1'b0;

endpackage

>>> rtl/srms_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srms_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module srms_ram #(
   parameter int WIDTH = 38,
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr0,
   output logic [WIDTH-1:0] rdata0,
   input  logic [AW-1:0]    raddr1,
   output logic [WIDTH-1:0] rdata1
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
   end

endmodule

>>> rtl/stable_run_merge_sorter_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stable_run_merge_sorter_unit
// Loads signed keys, sorts them stably and streams them out with positions.
// ---------------------------------------------------------------------------
// Usage: keys arrive on the req_ channel, one item per cycle while loading.
// The item with req_last_in set closes the list; req_stall then stays high
// until every sorted item has been taken on the rsp_ channel. Each result
// carries the key (low KEY_BITS bits), its load position, the overflow flag
// (items beyond MAX_ITEMS were dropped) and rsp_last_out on the final one.
// Sorting is a bottom-up merge over two ping-pong RAMs with two read ports:
// each pass writes one element per cycle, after a priming state for each merged
// pair of runs, over ceil(log2(n)) passes. Output reads each item from the RAM,
// then loads it into the output register, one result at a time.
// A stalled result holds in the output register; the sorter just waits.
// Reset (synchronous, active high) empties the list and clears descending.
// The configuration port holds one register, descending, at byte address 0.
// ---------------------------------------------------------------------------
module stable_run_merge_sorter_unit #(
   parameter int MAX_ITEMS = srms_pkg::MAX_ITEMS_DEF,
   parameter int KEY_BITS  = srms_pkg::KEY_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // load side
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [srms_pkg::KEY_PORT_BITS-1:0] req_key,
   input  logic                               req_last_in,
   // result side
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [srms_pkg::KEY_PORT_BITS-1:0] rsp_sorted_key,
   output logic [srms_pkg::POS_BITS-1:0]      rsp_source_position,
   output logic                               rsp_overflow,
   output logic                               rsp_last_out,
   // configuration
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [2:0]                         paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   localparam int AW  = $clog2(MAX_ITEMS);
   localparam int CW  = $clog2(MAX_ITEMS + 1);
   localparam int SW  = CW + 2;
   localparam int PB  = srms_pkg::POS_BITS;
   localparam int EW  = KEY_BITS + PB;
   localparam int OKB = (KEY_BITS < srms_pkg::KEY_PORT_BITS) ?
                        KEY_BITS : srms_pkg::KEY_PORT_BITS;

   localparam logic [2:0] S_LOAD     = 3'd0;
   localparam logic [2:0] S_PRIME    = 3'd1;
   localparam logic [2:0] S_MERGE    = 3'd2;
   localparam logic [2:0] S_OUT_RD   = 3'd3;
   localparam logic [2:0] S_OUT_LD   = 3'd4;
   localparam logic [2:0] S_OUT_HOLD = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          desc_ff, desc_in;
   logic          src_ff, src_in;
   logic [CW-1:0] width_ff, width_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] a_ff, a_in;
   logic [CW-1:0] b_ff, b_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] right_ff, right_in;
   logic [CW-1:0] idx_ff, idx_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [srms_pkg::KEY_PORT_BITS-1:0] rsp_key_ff, rsp_key_in;
   logic [PB-1:0]                    rsp_pos_ff, rsp_pos_in;
   logic                             rsp_ovf_ff, rsp_ovf_in;
   logic                             rsp_last_ff, rsp_last_in;

   // RAM ports
   logic          we0, we1;
   logic [AW-1:0] waddr;
   logic [EW-1:0] wdata;
   logic [AW-1:0] raddr0, raddr1;
   logic [EW-1:0] r0_d0, r0_d1, r1_d0, r1_d1;
   logic [EW-1:0] ha, hb;

   srms_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_bank0 (
      .clock(clock), .we(we0), .waddr(waddr), .wdata(wdata),
      .raddr0(raddr0), .rdata0(r0_d0), .raddr1(raddr1), .rdata1(r0_d1)
   );

   srms_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_bank1 (
      .clock(clock), .we(we1), .waddr(waddr), .wdata(wdata),
      .raddr0(raddr0), .rdata0(r1_d0), .raddr1(raddr1), .rdata1(r1_d1)
   );

   assign ha = src_ff ? r1_d0 : r0_d0;
   assign hb = src_ff ? r1_d1 : r0_d1;

   function automatic logic [CW-1:0] clamp_n(input logic [SW-1:0] v,
                                             input logic [CW-1:0] n);
      logic [SW-1:0] nw;
      nw = SW'(n);
      clamp_n = (v > nw) ? n : v[CW-1:0];
   endfunction

   // config port
   logic cfg_wr;
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == srms_pkg::CSR_IDX_DESCENDING) ?
                   {31'd0, desc_ff} : 32'd0;

   always_comb begin
      desc_in = desc_ff;
      if (cfg_wr && paddr[2] == srms_pkg::CSR_IDX_DESCENDING) begin
         desc_in = pwdata[0];
      end
   end

   // merge datapath
   logic signed [KEY_BITS-1:0] ka, kb;
   logic          a_done, b_done, b_first, take_b;
   logic [CW-1:0] a_nx, b_nx, k_nx;
   logic [SW-1:0] next_left_w;
   logic [CW-1:0] w_dbl;
   logic          req_acc, rsp_acc;

   assign ka      = ha[EW-1:PB];
   assign kb      = hb[EW-1:PB];
   assign a_done  = a_ff >= mid_ff;
   assign b_done  = b_ff >= right_ff;
   assign b_first = desc_ff ? (kb > ka) : (kb < ka);
   assign take_b  = a_done || (!b_done && b_first);
   assign a_nx    = take_b ? a_ff : a_ff + CW'(1);
   assign b_nx    = take_b ? b_ff + CW'(1) : b_ff;
   assign k_nx    = k_ff + CW'(1);
   assign w_dbl   = {width_ff[CW-2:0], 1'b0};

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != S_LOAD);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      src_in       = src_ff;
      width_in     = width_ff;
      k_in         = k_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      mid_in       = mid_ff;
      right_in     = right_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      we0          = 1'b0;
      we1          = 1'b0;
      waddr        = count_ff[AW-1:0];
      wdata        = {KEY_BITS'(req_key), PB'(count_ff)};
      raddr0       = a_ff[AW-1:0];
      raddr1       = b_ff[AW-1:0];
      next_left_w  = '0;

      case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (count_ff < CW'(MAX_ITEMS)) begin
                  we0      = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_in) begin
                  src_in   = 1'b0;
                  idx_in   = '0;
                  width_in = CW'(1);
                  k_in     = '0;
                  a_in     = '0;
                  mid_in   = clamp_n(SW'(1), count_in);
                  b_in     = clamp_n(SW'(1), count_in);
                  right_in = clamp_n(SW'(2), count_in);
                  state_in = (count_in < CW'(2)) ? S_OUT_RD : S_PRIME;
               end
            end
         end
         S_PRIME: begin
            state_in = S_MERGE;
         end
         S_MERGE: begin
            waddr  = k_ff[AW-1:0];
            wdata  = take_b ? hb : ha;
            we0    = src_ff;
            we1    = !src_ff;
            raddr0 = a_nx[AW-1:0];
            raddr1 = b_nx[AW-1:0];
            a_in   = a_nx;
            b_in   = b_nx;
            k_in   = k_nx;
            if (k_nx == right_ff) begin
               // segment finished: set up the next pair of runs, the next pass or the output
               if (right_ff >= count_ff) begin
                  src_in   = !src_ff;
                  width_in = w_dbl;
                  if (w_dbl >= count_ff) begin
                     idx_in   = '0;
                     state_in = S_OUT_RD;
                  end else begin
                     next_left_w = '0;
                     k_in     = '0;
                     a_in     = '0;
                     mid_in   = clamp_n(SW'(w_dbl), count_ff);
                     b_in     = clamp_n(SW'(w_dbl), count_ff);
                     right_in = clamp_n(SW'(w_dbl) + SW'(w_dbl), count_ff);
                     state_in = S_PRIME;
                  end
               end else begin
                  next_left_w = SW'(right_ff);
                  k_in     = right_ff;
                  a_in     = right_ff;
                  mid_in   = clamp_n(next_left_w + SW'(width_ff), count_ff);
                  b_in     = clamp_n(next_left_w + SW'(width_ff), count_ff);
                  right_in = clamp_n(next_left_w + SW'(w_dbl), count_ff);
                  state_in = S_PRIME;
               end
            end
         end
         S_OUT_RD: begin
            raddr0   = idx_ff[AW-1:0];
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = srms_pkg::KEY_PORT_BITS'(ha[PB +: OKB]);
            rsp_pos_in   = ha[PB-1:0];
            rsp_ovf_in   = ovf_ff;
            rsp_last_in  = (idx_ff + CW'(1) == count_ff);
            state_in     = S_OUT_HOLD;
         end
         S_OUT_HOLD: begin
            raddr0 = idx_ff[AW-1:0] + AW'(1);
            if (rsp_acc) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_OUT_LD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         desc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         desc_ff      <= desc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      width_ff    <= width_in;
      k_ff        <= k_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      mid_ff      <= mid_in;
      right_ff    <= right_in;
      idx_ff      <= idx_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sorted_key      = rsp_key_ff;
   assign rsp_source_position = rsp_pos_ff;
   assign rsp_overflow        = rsp_ovf_ff;
   assign rsp_last_out        = rsp_last_ff;

   // ---------------------------------------------------------------------
   a_rsp_blocks_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("result pending while loading");

   a_merge_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE) |-> (k_ff < count_ff))
      else $error("merge write index beyond list");

   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_last_out) |=> (state_ff == S_LOAD && count_ff == '0))
      else $error("list not cleared after final item");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == CW'(MAX_ITEMS)))
      else $error("overflow flagged with room left");

endmodule

>>> verif/stable_run_merge_sorter_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stable_run_merge_sorter_unit_tb
// Self-checking bench for the sorter. It loads keys, predicts the stable
// sorted output on each list close and checks every streamed result in order.
// Lists vary from single keys to overflowing ones, in both sort directions.
// ---------------------------------------------------------------------------
class sort_scoreboard;
   typedef struct {
      logic [31:0] key;
      logic [5:0]  pos;
      logic        ovf;
      logic        last;
   } sorted_entry_type;

   sorted_entry_type pending[$];
   logic signed [31:0] held_key[$];
   bit    dropped;
   bit    desc;
   int    errors;

   function void clear_list();
      held_key.delete();
      dropped = 0;
   endfunction

   // a goes strictly before b
   function bit ahead(logic signed [31:0] a, logic signed [31:0] b);
      return desc ? (a > b) : (a < b);
   endfunction

   function void note_load(logic signed [31:0] key, bit last_flag);
      logic signed [31:0] k[$];
      int p[$];
      int n;
      int j;
      logic signed [31:0] ck;
      int cp;
      sorted_entry_type e;
      if (held_key.size() < 64) held_key.push_back(key);
      else dropped = 1;
      if (!last_flag) return;
      n = held_key.size();
      for (int i = 0; i < n; i++) begin
         k.push_back(held_key[i]);
         p.push_back(i);
      end
      // stable insertion sort gives the same order as any stable sort
      for (int i = 1; i < n; i++) begin
         ck = k[i];
         cp = p[i];
         j = i;
         while (j > 0 && ahead(ck, k[j-1])) begin
            k[j] = k[j-1];
            p[j] = p[j-1];
            j--;
         end
         k[j] = ck;
         p[j] = cp;
      end
      for (int i = 0; i < n; i++) begin
         e.key = k[i];
         e.pos = p[i][5:0];
         e.ovf = dropped;
         e.last = (i == n - 1);
         pending.push_back(e);
      end
      clear_list();
   endfunction

   function void check_result(logic [31:0] key, logic [5:0] pos, logic ovf, logic last);
      sorted_entry_type e;
      if (pending.size() == 0) begin
         $error("unexpected result key=%h", key);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (key !== e.key) begin
         $error("sorted_key exp %h got %h", e.key, key);
         errors++;
      end
      if (pos !== e.pos) begin
         $error("source_position exp %0d got %0d", e.pos, pos);
         errors++;
      end
      if (ovf !== e.ovf) begin
         $error("overflow exp %0b got %0b", e.ovf, ovf);
         errors++;
      end
      if (last !== e.last) begin
         $error("last_out exp %0b got %0b", e.last, last);
         errors++;
      end
   endfunction
endclass

module stable_run_merge_sorter_unit_tb;

   localparam int CYCLE_LIMIT = 600000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [srms_pkg::KEY_PORT_BITS-1:0] req_key = '0;
   logic req_last_in = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [srms_pkg::KEY_PORT_BITS-1:0] rsp_sorted_key;
   logic [srms_pkg::POS_BITS-1:0] rsp_source_position;
   logic rsp_overflow;
   logic rsp_last_out;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   int send_idle_pct = 10;
   int recv_idle_pct = 65;
   int hold_off_cycles = 0;
   int cycle_count = 0;
   sort_scoreboard sb;

   stable_run_merge_sorter_unit dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: check at the rising edge, choose stall at the falling edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_sorted_key, rsp_source_position, rsp_overflow, rsp_last_out);
   end

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic write_direction(bit desc);
      @(negedge clock);
      psel <= 1;
      pwrite <= 1;
      paddr <= {srms_pkg::CSR_IDX_DESCENDING, 2'b00};
      pwdata <= {31'b0, desc};
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      sb.desc = desc;
   endtask

   // offer one item until accepted; random idle gaps before it
   task automatic load_key(logic signed [31:0] key, bit last_flag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_key <= key;
      req_last_in <= last_flag;
      do @(posedge clock); while (req_stall);
      sb.note_load(key, last_flag);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_key(int pool);
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(pool)) - pool / 2;
         2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $urandom_range(pool);
      endcase
   endfunction

   task automatic load_list(int n, int pool);
      for (int i = 0; i < n; i++)
         load_key(rand_key(pool), i == n - 1);
   endtask

   int sent;
   int len;

   initial begin
      sb = new();
      repeat (7) @(negedge clock);
      reset <= 0;
      // directed: extremes, equal keys, single element, both directions
      load_key(32'sh7fffffff, 0);
      load_key(32'sh80000000, 0);
      load_key(0, 0);
      load_key(-1, 0);
      load_key(5, 0);
      load_key(5, 1);
      load_key(42, 1);
      drain();
      write_direction(1);
      load_key(-7, 0);
      load_key(32'sh80000000, 0);
      load_key(3, 0);
      load_key(3, 0);
      load_key(32'sh7fffffff, 1);
      drain();
      // receiver holds off while a full list plus overflow is offered,
      // then the next list waits on a stalled input
      hold_off_cycles = 900;
      write_direction(0);
      load_list(70, 9);
      load_list(5, 9);
      drain();
      sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 65 : 0;
         recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 10 : 0;
         while (sent < (phase + 1) * 110) begin
            case ($urandom_range(9))
               0: len = 64;
               1: len = $urandom_range(65, 68);
               2: len = 1;
               default: len = $urandom_range(2, 40);
            endcase
            load_list(len, $urandom_range(1) ? 6 : 1000);
            sent += len;
            if ($urandom_range(3) == 0) begin
               // sender pauses until all results are in, then may flip order
               drain();
               write_direction($urandom_range(1));
            end
         end
      end
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
